@@ rtl/salc_pkg.sv @@
// Shared codes and field widths for the set-associative LRU tag store.
// No dependencies; imported by set_assoc_lru_cache_tags.
package salc_pkg;

	localparam int ADDR_W = 64;
	localparam int KIND_W = 2;
	localparam int OUT_W  = 2;
	localparam int CNT_W  = 32;
	localparam int CFG_W  = 6;
	localparam int CFG_IDX_W = 2;

	// Output tdata: outcome, three totals, padded to whole bytes
	localparam int RES_W   = OUT_W + 3 * CNT_W;
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

	// Access kinds; any other code behaves as a load
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

	typedef enum logic [OUT_W-1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

endpackage

@@ rtl/set_assoc_lru_cache_tags.sv @@
// Top level of the set-associative tag store with true LRU replacement.
// Depends on salc_pkg for field widths, register indexes and outcome codes.
// Holds the set memory, lookup/update stage and output register.

// Tag store of a set-associative cache. Each access (s_tdata = byte address,
// s_tuser = access kind) is looked up in the set picked by the address bits
// just above the block offset; the result reports hit, miss with fill or miss
// with eviction, together with the running hit, miss and eviction totals.
// Each access reads its set row from a one-port-read, one-port-write memory
// into a register at the transfer; the lookup stage then compares all ways,
// picks the line, updates the recency ranks and writes the whole row back
// when the output register can take the result; s_tready stays low until then,
// so one access is in flight at a time and two accesses to the same set never
// overlap. A result waits in an output register; the next access is taken
// while it waits, and its write-back stage holds until the output register
// frees. Line valid state is kept per way inside each row, plus one flag per
// set in flip-flops that marks the row as written; reset clears those flags
// at once, so there is no clearing pass. Configuration (set_bits, block_bits,
// ways) must only be written while no access is in flight.
module set_assoc_lru_cache_tags
	import salc_pkg::*;
#(
	parameter int MAX_SETS = 256,
	parameter int MAX_WAYS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,

	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [ADDR_W-1:0]    s_tdata,   // [63:0] address
	input  logic [KIND_W-1:0]    s_tuser,   // [1:0] access_kind

	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [1:0] outcome, [33:2] hit_total, [65:34] miss_total,
	// [97:66] eviction_total, rest zero
	output logic [TDATA_W-1:0]   m_tdata
);

	// Largest k with 2^k <= MAX_SETS
	localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int SETS   = 1 << SET_BITS_MAX;
	localparam int SET_W  = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam int NW_W   = $clog2(MAX_WAYS + 1) + 1;

	typedef struct packed {
		logic              vld;
		logic [ADDR_W-1:0] tag;
		logic [RANK_W-1:0] rank;
	} line_t;

	typedef line_t [MAX_WAYS-1:0] row_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Configuration registers
	logic [3:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_q;

	// Control
	logic busy_q;
	logic out_vld_q;
	logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic [SETS-1:0] row_init_q;

	// Stage 1 payload
	logic [SET_W-1:0]  set_s1;
	logic [ADDR_W-1:0] tag_s1;
	logic [KIND_W-1:0] kind_s1;
	logic              row_live_s1;
	row_t              rd_row_s1;

	row_t line_mem_q [SETS];
	logic [TDATA_W-1:0] out_data_q;

	// ---------------- Address split at the transfer ----------------
	logic              accept;
	logic [3:0]        sb;
	logic [ADDR_W-1:0] blk;
	logic [ADDR_W-1:0] tag_in;
	logic [SET_W-1:0]  set_mask;
	logic [SET_W-1:0]  set_in;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		sb = (set_bits_q > 4'(SET_BITS_MAX)) ? 4'(SET_BITS_MAX) : set_bits_q;
		blk = s_tdata >> block_bits_q;
		tag_in = blk >> sb;
		for (int i = 0; i < SET_W; i++) begin
			set_mask[i] = (i < int'(sb));
		end
		set_in = blk[SET_W-1:0] & set_mask;
	end

	// ---------------- Lookup and update ----------------
	logic [NW_W-1:0]     nw;
	row_t                cur_row;
	row_t                new_row;
	logic [MAX_WAYS-1:0] in_use, hit_vec, free_vec, max_vec;
	logic [WAY_W-1:0]    hit_way, free_way, evict_way, sel_way;
	logic                is_hit, is_fill, was_valid;
	logic [RANK_W-1:0]   sel_rank;
	logic                fire;
	outcome_t            outcome;
	logic [CNT_W-1:0]    hit_nxt, miss_nxt, evict_nxt;

	// Write back only when the output register can take the result
	assign fire = busy_q && (!out_vld_q || m_tready);

	always_comb begin
		if (ways_q == 4'd0) begin
			nw = NW_W'(1);
		end else if (NW_W'(ways_q) > NW_W'(MAX_WAYS)) begin
			nw = NW_W'(MAX_WAYS);
		end else begin
			nw = NW_W'(ways_q);
		end

		cur_row = row_live_s1 ? rd_row_s1 : '0;

		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i]   = (NW_W'(i) < nw);
			hit_vec[i]  = in_use[i] && cur_row[i].vld && (cur_row[i].tag == tag_s1);
			free_vec[i] = in_use[i] && !cur_row[i].vld;
			// first way in use that holds the oldest rank
			max_vec[i]  = in_use[i];
			for (int j = 0; j < MAX_WAYS; j++) begin
				if (in_use[j] && j != i) begin
					if (j < i) begin
						if (!(cur_row[j].rank < cur_row[i].rank)) max_vec[i] = 1'b0;
					end else begin
						if (cur_row[j].rank > cur_row[i].rank) max_vec[i] = 1'b0;
					end
				end
			end
		end

		hit_way   = '0;
		free_way  = '0;
		evict_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i])  hit_way   = WAY_W'(i);
			if (free_vec[i]) free_way  = WAY_W'(i);
			if (max_vec[i])  evict_way = WAY_W'(i);
		end

		is_hit    = |hit_vec;
		is_fill   = !is_hit && (|free_vec);
		was_valid = !is_fill;
		if (is_hit) begin
			sel_way = hit_way;
			outcome = OUT_HIT;
		end else if (is_fill) begin
			sel_way = free_way;
			outcome = OUT_FILL;
		end else begin
			sel_way = evict_way;
			outcome = OUT_EVICT;
		end
		sel_rank = cur_row[sel_way].rank;

		// Touched line becomes most recent; younger valid lines age by one (all valid lines on a fill)
		for (int i = 0; i < MAX_WAYS; i++) begin
			new_row[i] = cur_row[i];
			if (WAY_W'(i) == sel_way) begin
				new_row[i].vld  = 1'b1;
				new_row[i].tag  = tag_s1;
				new_row[i].rank = '0;
			end else if (cur_row[i].vld && (!was_valid || cur_row[i].rank < sel_rank)) begin
				new_row[i].rank = cur_row[i].rank + 1'b1;
			end
		end

		hit_nxt = is_hit ? sat_inc(hit_cnt_q) : hit_cnt_q;
		if (kind_s1 == KIND_MODIFY) begin
			hit_nxt = sat_inc(hit_nxt);
		end
		miss_nxt  = is_hit ? miss_cnt_q : sat_inc(miss_cnt_q);
		evict_nxt = (outcome == OUT_EVICT) ? sat_inc(evict_cnt_q) : evict_cnt_q;
	end

	// ---------------- Set memory ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_s1 <= line_mem_q[set_in];
		end
		if (fire) begin
			line_mem_q[set_s1] <= new_row;
		end
	end

	// ---------------- Stage payload and result data ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1      <= set_in;
			tag_s1      <= tag_in;
			kind_s1     <= s_tuser;
			row_live_s1 <= row_init_q[set_in];
		end
		if (fire) begin
			out_data_q <= TDATA_W'({evict_nxt, miss_nxt, hit_nxt, outcome});
		end
	end

	// ---------------- Control, counters, configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 4'd4;
			block_bits_q <= 6'd4;
			ways_q       <= 4'd1;
			busy_q       <= 1'b0;
			out_vld_q    <= 1'b0;
			hit_cnt_q    <= '0;
			miss_cnt_q   <= '0;
			evict_cnt_q  <= '0;
			row_init_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
					REG_BLOCK_BITS: block_bits_q <= cfg_data;
					REG_WAYS:       ways_q       <= cfg_data[3:0];
					default:        ;
				endcase
			end
			if (m_tready && !fire) begin
				out_vld_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (fire) begin
				busy_q             <= 1'b0;
				out_vld_q          <= 1'b1;
				hit_cnt_q          <= hit_nxt;
				miss_cnt_q         <= miss_nxt;
				evict_cnt_q        <= evict_nxt;
				row_init_q[set_s1] <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	// An accepted access closes the input, so no second access is taken behind it
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input accepted while an access is in flight");

	// The replaced or touched line is always one of the ways in use
	a_way_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> in_use[sel_way])
		else $error("selected way outside the ways in use");

	// Totals never go down
	a_totals_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (hit_cnt_q >= $past(hit_cnt_q)) && (miss_cnt_q >= $past(miss_cnt_q))
			&& (evict_cnt_q >= $past(evict_cnt_q)))
		else $error("a running total decreased");
`endif

endmodule
